// File: rtl/isort_pkg.sv
package isort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VAL_W     = 32;

    typedef logic signed [VAL_W-1:0] t_val;

    // what one cell hands to its neighbors
    typedef struct packed {
        t_val val;
        logic occ;
        logic gt;
    } t_link;

    // broadcast control for the whole chain
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

endpackage

// File: rtl/isort_cell.sv
module isort_cell
    import isort_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_val      i_new,
    input  t_link     i_prev,
    input  t_link     i_next,
    output t_link     o_link
);

    t_val r_val;
    logic r_occ;
    t_val n_val;
    logic n_occ;
    logic w_gt;

    assign w_gt = r_occ && (r_val > i_new);

    always_comb begin
        n_val = r_val;
        n_occ = r_occ;
        if (i_ctl.insert) begin
            if (i_prev.gt) begin
                // larger entry below moves up into this place
                n_val = i_prev.val;
                n_occ = 1'b1;
            end else if (i_prev.occ && (!r_occ || w_gt)) begin
                // first place holding a larger value or the first free one
                n_val = i_new;
                n_occ = 1'b1;
            end
        end else if (i_ctl.shift) begin
            n_val = i_next.val;
            n_occ = i_next.occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_link = '{val: r_val, occ: r_occ, gt: w_gt};

endmodule

// File: rtl/insertion_sorter.sv
// Streaming insertion sorter for signed 32-bit values.
// Input channel (i_in_valid / o_in_ready) carries one value per request,
// i_final_item marking the last value of a set. Values enter a row of
// MAX_ITEMS cells that compare against the new value in parallel and shift
// larger entries up one cell, so one value is taken every cycle.
// After the marked request the block drains: the cell row shifts down one
// place per accepted result, starting the cycle after the marked request,
// with o_last_out on the final result and o_overflow on every result of a
// set in which values were dropped because all cells were occupied.
// A set yields one result per stored value (at most MAX_ITEMS) and no input
// is taken while the set drains, as o_in_ready is high only in the idle state.
// Equal values keep arrival order (a new value goes above equal entries).
// A stalled receiver (i_out_ready low) holds the row and the current result.
// Reset (i_rst_n low, synchronous) empties all cells, clears the overflow
// flag and returns to accepting input.
module insertion_sorter
    import isort_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_val i_value,
    input  logic i_final_item,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_val o_sorted_value,
    output logic o_last_out,
    output logic o_overflow
);

    t_state    r_state;
    t_state    n_state;
    logic      r_dropped;
    logic      n_dropped;
    t_cell_ctl w_ctl;
    t_link     w_link [MAX_ITEMS];
    logic      w_in_acc;
    logic      w_out_acc;
    logic      w_full;
    localparam t_link LINK_HEAD = '{val: '0, occ: 1'b1, gt: 1'b0};
    localparam t_link LINK_TAIL = '{val: '0, occ: 1'b0, gt: 1'b0};

    assign w_full    = w_link[MAX_ITEMS-1].occ;
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_final_item) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_out_acc && o_last_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == ST_IDLE);
        o_out_valid  = (r_state == ST_DRAIN) && w_link[0].occ;
        w_ctl.insert = w_in_acc && !w_full;
        w_ctl.shift  = w_out_acc;
    end

    always_comb begin
        n_dropped = r_dropped;
        if (w_in_acc && w_full) begin
            n_dropped = 1'b1;
        end else if (w_out_acc && o_last_out) begin
            n_dropped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dropped <= n_dropped;
        end
    end

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        t_link w_prev;
        t_link w_next;
        if (g == 0) begin : g_head
            assign w_prev = LINK_HEAD;
        end else begin : g_mid
            assign w_prev = w_link[g-1];
        end
        if (g == MAX_ITEMS - 1) begin : g_tail
            assign w_next = LINK_TAIL;
        end else begin : g_body
            assign w_next = w_link[g+1];
        end
        isort_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_new   (i_value),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_link  (w_link[g])
        );
    end

    assign o_sorted_value = w_link[0].val;
    assign o_last_out     = !w_link[1].occ;
    assign o_overflow     = r_dropped;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a set drains");

    a_drain_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_final_item) |=> o_out_valid)
        else $error("no result after the marked request");

    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_last_out) |=> (o_in_ready && !w_link[0].occ && !r_dropped))
        else $error("cells not empty after the last result");

    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[1].occ |-> w_link[0].occ)
        else $error("occupied cells not contiguous");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import isort_pkg::*;

    localparam int RUN_LIMIT    = 150000;
    localparam int RANDOM_ITEMS = 20;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_CAP    = 100;

    typedef struct packed {
        t_val val;
        logic last;
        logic ovf;
    } t_sorted_out;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    typedef enum logic [1:0] {
        VAL_ANY,
        VAL_TIES,
        VAL_EDGES
    } t_val_kind;

    logic i_clk        = 1'b0;
    logic i_rst_n      = 1'b0;
    logic i_in_valid   = 1'b0;
    t_val i_value      = '0;
    logic i_final_item = 1'b0;
    logic i_out_ready  = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_val o_sorted_value;
    logic o_last_out;
    logic o_overflow;

    // shadow of the cell row
    t_val        shadow_store [MAX_ITEMS];
    int          shadow_fill;
    logic        shadow_dropped;
    t_sorted_out pending_sorted [$];

    int          burst_left;
    int unsigned cycle_count;
    int          n_requests;
    int          n_sets;
    int          n_overflow_sets;
    int          n_results;
    int          n_errors;

    insertion_sorter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_value       (i_value),
        .i_final_item  (i_final_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sorted_value(o_sorted_value),
        .o_last_out    (o_last_out),
        .o_overflow    (o_overflow)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_sorted.size());
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // Insert one accepted value; on the marked value queue the whole sorted set.
    function automatic void insert_and_collect(input t_val v, input logic fin);
        int pos;
        t_sorted_out r;
        n_requests++;
        if (shadow_fill < MAX_ITEMS) begin
            pos = shadow_fill;
            while (pos > 0 && shadow_store[pos-1] > v) begin
                shadow_store[pos] = shadow_store[pos-1];
                pos--;
            end
            shadow_store[pos] = v;
            shadow_fill++;
        end else begin
            shadow_dropped = 1'b1;
        end
        if (fin) begin
            for (int k = 0; k < shadow_fill; k++) begin
                r.val  = shadow_store[k];
                r.last = (k == shadow_fill - 1);
                r.ovf  = shadow_dropped;
                pending_sorted.push_back(r);
            end
            n_sets++;
            if (shadow_dropped) n_overflow_sets++;
            shadow_fill    = 0;
            shadow_dropped = 1'b0;
        end
    endfunction

    // Called and returns at a rising edge; valid stays up for a following request.
    task automatic send_request(input t_val v, input logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_value      <= v;
        i_final_item <= fin;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        insert_and_collect(v, fin);
    endtask

    function automatic t_val rand_value(input t_val_kind kind);
        t_val v;
        case (kind)
            VAL_TIES: begin
                v = $signed($urandom_range(0, 7)) - 4;
            end
            VAL_EDGES: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = -1;
                    3: v = 0;
                    default: v = 1;
                endcase
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    task automatic send_set(input t_val vals [$]);
        foreach (vals[i]) begin
            send_request(vals[i], i == vals.size() - 1);
        end
    endtask

    task automatic test_extremes();
        send_set('{32'sh7fff_ffff, 32'sh8000_0000, -1, 0, 1, 32'sh8000_0001});
        send_set('{32'sh8000_0000});
        send_set('{32'sh7fff_ffff});
    endtask

    task automatic test_equal_values();
        send_set('{5, -3, 5, 5, -3});
        send_set('{-1, -1, -1});
    endtask

    task automatic test_descending();
        send_set('{4, 3, 2, 1, 0, -1});
    endtask

    // Fill the row, then overrun it by one so that the marked value is dropped.
    task automatic test_store_limits();
        t_val vals [$];
        for (int i = 0; i < MAX_ITEMS + 1; i++) begin
            vals.push_back(rand_value(i % 3 == 0 ? VAL_TIES : VAL_ANY));
        end
        send_set(vals);
    endtask

    task automatic test_random_sets();
        int sent;
        int size;
        int pick;
        t_val_kind kind;
        t_val vals [$];
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            size = (pick < 7) ? $urandom_range(1, 8) : $urandom_range(9, 20);
            pick = $urandom_range(0, 19);
            kind = (pick < 12) ? VAL_ANY : (pick < 17) ? VAL_TIES : VAL_EDGES;
            vals.delete();
            for (int i = 0; i < size; i++) begin
                // mix value kinds inside some sets
                vals.push_back(rand_value(kind == VAL_EDGES ?
                                          t_val_kind'($urandom_range(0, 2)) : kind));
            end
            send_set(vals);
            sent += size;
        end
    endtask

    // Receiver ready pattern: pick a random mode and hold it for a random span.
    always @(posedge i_clk) begin
        static t_rx_mode rx_mode = RX_OPEN;
        static int rx_left = 0;
        static logic rx_toggle = 1'b0;
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 80);
        end else begin
            rx_left--;
        end
        rx_toggle = ~rx_toggle;
        case (rx_mode)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= $urandom_range(0, 1);
            RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
            default:   i_out_ready <= rx_toggle;
        endcase
    end

    // Inputs only change at rising edges, so the falling edge shows what the next edge takes.
    always @(negedge i_clk) begin
        t_sorted_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pending_sorted.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%0d last=%0b ovf=%0b",
                                          o_sorted_value, o_last_out, o_overflow));
            end else begin
                want = pending_sorted.pop_front();
                if (o_sorted_value !== want.val) begin
                    report_mismatch($sformatf("sorted_value got %0d want %0d",
                                              o_sorted_value, want.val));
                end
                if (o_last_out !== want.last) begin
                    report_mismatch($sformatf("last_out got %0b want %0b (value %0d)",
                                              o_last_out, want.last, want.val));
                end
                if (o_overflow !== want.ovf) begin
                    report_mismatch($sformatf("overflow got %0b want %0b (value %0d)",
                                              o_overflow, want.ovf, want.val));
                end
            end
        end
    end

    initial begin
        shadow_fill    = 0;
        shadow_dropped = 1'b0;
        burst_left     = 0;
        cycle_count    = 0;
        n_requests     = 0;
        n_sets         = 0;
        n_overflow_sets = 0;
        n_results      = 0;
        n_errors       = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_equal_values();
        test_descending();
        test_store_limits();
        test_random_sets();

        i_in_valid <= 1'b0;
        while (pending_sorted.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests in %0d sets (%0d with dropped values)",
                 n_requests, n_sets, n_overflow_sets);
        $display("checked %0d sorted results, %0d mismatches", n_results, n_errors);
        if (n_errors == 0 && pending_sorted.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/isort_pkg.sv
rtl/isort_cell.sv
rtl/insertion_sorter.sv
tb/testbench.sv
